// ----- design/ssb_pkg.sv -----
// Package for the strided slice bounds block: item structs, internal control
// structs and fixed widths. No dependencies.
package ssb_pkg;

    localparam int SIZE_W     = 31;
    localparam int VAL_W      = 32;
    localparam int ALU_W      = 34;
    localparam int MASK_W     = 6;
    localparam int DIM_CNT_W  = 3;
    localparam int MASK_EXT_W = 1 << DIM_CNT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = SIZE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEGIN_MASK  = 2'd0,
        CFG_END_MASK    = 2'd1,
        CFG_SHRINK_MASK = 2'd2,
        CFG_KEEP_SHRUNK = 2'd3
    } ssb_cfg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       axis_len;
        logic signed [VAL_W-1:0] start_value;
        logic signed [VAL_W-1:0] end_value;
        logic signed [VAL_W-1:0] stride_value;
        logic                    has_start;
        logic                    has_end;
        logic                    has_stride;
        logic                    last_dim;
    } ssb_in_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       start_abs;
        logic signed [VAL_W-1:0] end_abs;
        logic signed [VAL_W-1:0] stride_out;
        logic [SIZE_W-1:0]       out_extent;
        logic                    dim_kept;
        logic [DIM_CNT_W-1:0]    out_position;
        logic                    shape_empty;
        logic                    last_out;
    } ssb_out_t;

    typedef struct packed {
        logic begin_ign;
        logic end_ign;
        logic shrink;
    } ssb_dim_ctl_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       start_abs;
        logic signed [VAL_W-1:0] end_abs;
        logic signed [VAL_W-1:0] stride_out;
        logic [SIZE_W-1:0]       extent;
        logic                    range_empty;
        logic                    shrink;
        logic                    last;
    } ssb_core_res_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } ssb_alu_flags_t;

endpackage

// ----- design/ssb_addsub.sv -----
// Shared add/subtract unit of the slice bounds sequencer.
// Depends on ssb_pkg for the datapath width and flag struct.
module ssb_addsub
    import ssb_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  logic             sub,
    output logic [ALU_W-1:0] sum,
    output ssb_alu_flags_t   flags
);

    assign sum        = a + (b ^ {ALU_W{sub}}) + {{(ALU_W-1){1'b0}}, sub};
    assign flags.neg  = sum[ALU_W-1];
    assign flags.zero = (sum == '0);

endmodule

// ----- design/ssb_core.sv -----
// Sequencer for one dimension: wrap, clamp, range and radix-2 extent division,
// all through one ssb_addsub instance. Depends on ssb_pkg and ssb_addsub.
module ssb_core
    import ssb_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssb_in_t       in_item,
    input  ssb_dim_ctl_t  dim_ctl,
    output logic          res_valid,
    input  logic          res_take,
    output ssb_core_res_t res
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [ALU_W-1:0] ONE     = ALU_W'(1);
    localparam logic [ALU_W-1:0] VAL_MAX = {{(ALU_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic [ALU_W-1:0] VAL_MIN = {{(ALU_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SIZEM1 = 13'b0000000000010,
        ST_SWRAP  = 13'b0000000000100,
        ST_SCLAMP = 13'b0000000001000,
        ST_EINIT  = 13'b0000000010000,
        ST_EWRAP  = 13'b0000000100000,
        ST_ECLAMP = 13'b0000001000000,
        ST_RANGE  = 13'b0000010000000,
        ST_RABS   = 13'b0000100000000,
        ST_SABS   = 13'b0001000000000,
        ST_DIV    = 13'b0010000000000,
        ST_CEIL   = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ALU_W-1:0]  size_m1_reg, size_m1_next;
    logic [ALU_W-1:0]  start_reg, start_next;
    logic [ALU_W-1:0]  end_reg, end_next;
    logic [ALU_W-1:0]  range_reg, range_next;
    logic [VAL_W-1:0]  stride_reg, stride_next;
    logic [VAL_W-1:0]  div_reg, div_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [SIZE_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic has_s_reg, has_s_next;
    logic has_e_reg, has_e_next;
    logic end_ign_reg, end_ign_next;
    logic shrink_reg, shrink_next;
    logic last_reg, last_next;
    logic empty_reg, empty_next;

    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub;
    ssb_alu_flags_t   alu_flags;

    logic [VAL_W-1:0] in_stride;
    logic             in_stride_pos;
    logic             stride_pos;
    logic [ALU_W-1:0] size_ext;
    logic [ALU_W-1:0] end_hi;
    logic [ALU_W-1:0] clamp_mid;
    logic [VAL_W-1:0] shifted;

    ssb_addsub u_addsub (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .flags (alu_flags)
    );

    assign in_stride     = in_item.has_stride ? in_item.stride_value : VAL_W'(1);
    assign in_stride_pos = !in_stride[VAL_W-1] && (in_stride != '0);
    assign stride_pos    = !stride_reg[VAL_W-1] && (stride_reg != '0);
    assign size_ext      = {{(ALU_W-SIZE_W){1'b0}}, size_reg};
    assign end_hi        = stride_pos ? size_ext : size_m1_reg;
    assign shifted       = {rem_reg[VAL_W-2:0], q_reg[SIZE_W-1]};
    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_SIZEM1: begin
                alu_a = size_ext; alu_b = ONE; alu_sub = 1'b1;
            end
            ST_SWRAP: begin
                alu_a = start_reg; alu_b = size_ext;
            end
            ST_SCLAMP: begin
                alu_a = size_m1_reg; alu_b = start_reg; alu_sub = 1'b1;
            end
            ST_EINIT: begin
                alu_a = start_reg; alu_b = ONE;
            end
            ST_EWRAP: begin
                alu_a = end_reg; alu_b = size_ext;
            end
            ST_ECLAMP: begin
                alu_a = end_hi; alu_b = end_reg; alu_sub = 1'b1;
            end
            ST_RANGE: begin
                alu_a = end_reg; alu_b = start_reg; alu_sub = 1'b1;
            end
            ST_RABS: begin
                alu_b = range_reg; alu_sub = 1'b1;
            end
            ST_SABS: begin
                alu_b = {{(ALU_W-VAL_W){stride_reg[VAL_W-1]}}, stride_reg}; alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = {{(ALU_W-VAL_W){1'b0}}, shifted};
                alu_b   = {{(ALU_W-VAL_W){1'b0}}, div_reg};
                alu_sub = 1'b1;
            end
            ST_CEIL: begin
                alu_a = {{(ALU_W-SIZE_W){1'b0}}, q_reg}; alu_b = ONE;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        size_m1_next = size_m1_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        range_next   = range_reg;
        stride_next  = stride_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        has_s_next   = has_s_reg;
        has_e_next   = has_e_reg;
        end_ign_next = end_ign_reg;
        shrink_next  = shrink_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        clamp_mid    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    size_next    = in_item.axis_len;
                    stride_next  = in_stride;
                    has_s_next   = in_item.has_start;
                    has_e_next   = in_item.has_end;
                    end_ign_next = dim_ctl.end_ign;
                    shrink_next  = dim_ctl.shrink;
                    last_next    = in_item.last_dim;
                    end_next     = {{(ALU_W-VAL_W){in_item.end_value[VAL_W-1]}},
                                    in_item.end_value};
                    if (!in_item.has_start) begin
                        start_next = '0;
                    end else if (dim_ctl.begin_ign) begin
                        start_next = in_stride_pos ? VAL_MIN : VAL_MAX;
                    end else begin
                        start_next = {{(ALU_W-VAL_W){in_item.start_value[VAL_W-1]}},
                                      in_item.start_value};
                    end
                    state_next = ST_SIZEM1;
                end
            end
            ST_SIZEM1: begin
                size_m1_next = alu_sum;
                state_next   = ST_SWRAP;
            end
            ST_SWRAP: begin
                if (has_s_reg && start_reg[ALU_W-1]) begin
                    start_next = alu_sum;
                end
                state_next = ST_SCLAMP;
            end
            ST_SCLAMP: begin
                clamp_mid  = alu_flags.neg ? size_m1_reg : start_reg;
                start_next = clamp_mid[ALU_W-1] ? '0 : clamp_mid;
                state_next = ST_EINIT;
            end
            ST_EINIT: begin
                if (!has_e_reg) begin
                    end_next = size_ext;
                end else if (shrink_reg) begin
                    end_next = alu_sum;
                end else if (end_ign_reg) begin
                    end_next = stride_pos ? VAL_MAX : VAL_MIN;
                end
                state_next = ST_EWRAP;
            end
            ST_EWRAP: begin
                if (has_e_reg && end_reg[ALU_W-1]) begin
                    end_next = alu_sum;
                end
                state_next = ST_ECLAMP;
            end
            ST_ECLAMP: begin
                clamp_mid = alu_flags.neg ? end_hi : end_reg;
                if (has_e_reg) begin
                    if (stride_pos) begin
                        end_next = clamp_mid[ALU_W-1] ? '0 : clamp_mid;
                    end else begin
                        end_next = (clamp_mid[ALU_W-1] && !(&clamp_mid)) ? '1 : clamp_mid;
                    end
                end
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                range_next = alu_sum;
                empty_next = alu_flags.zero
                           || (alu_flags.neg && !stride_reg[VAL_W-1])
                           || (!alu_flags.neg && !stride_pos);
                state_next = ST_RABS;
            end
            ST_RABS: begin
                q_next     = range_reg[ALU_W-1] ? alu_sum[SIZE_W-1:0]
                                                : range_reg[SIZE_W-1:0];
                state_next = ST_SABS;
            end
            ST_SABS: begin
                div_next   = stride_reg[VAL_W-1] ? alu_sum[VAL_W-1:0] : stride_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (alu_flags.neg) begin
                    rem_next = shifted;
                    q_next   = {q_reg[SIZE_W-2:0], 1'b0};
                end else begin
                    rem_next = alu_sum[VAL_W-1:0];
                    q_next   = {q_reg[SIZE_W-2:0], 1'b1};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_CEIL;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_CEIL: begin
                if (rem_reg != '0) begin
                    q_next = alu_sum[SIZE_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg    <= size_next;
        size_m1_reg <= size_m1_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        range_reg   <= range_next;
        stride_reg  <= stride_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        has_s_reg   <= has_s_next;
        has_e_reg   <= has_e_next;
        end_ign_reg <= end_ign_next;
        shrink_reg  <= shrink_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
    end

    assign res.start_abs   = start_reg[SIZE_W-1:0];
    assign res.end_abs     = end_reg[VAL_W-1:0];
    assign res.stride_out  = stride_reg;
    assign res.extent      = q_reg;
    assign res.range_empty = empty_reg;
    assign res.shrink      = shrink_reg;
    assign res.last        = last_reg;

endmodule

// ----- design/strided_slice_bounds_top.sv -----
// Strided slice bounds: one item per dimension. The core takes no new item
// until it has finished the last one: a 31-step radix-2 extent division and
// nine set-up steps (wrap, clamp, range, sign) on the one shared adder.
// A finished item waits in the output register while the next is accepted.
// aresetn (synchronous, active low) clears the masks, the dimension and
// output counters, the empty flag and all valid state.
// Depends on ssb_pkg and ssb_core.
module strided_slice_bounds_top
    import ssb_pkg::*;
#(
    parameter int MAX_DIMS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ssb_in_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ssb_out_t             m_item
);

    logic [MASK_W-1:0]    begin_mask_reg, begin_mask_next;
    logic [MASK_W-1:0]    end_mask_reg, end_mask_next;
    logic [MASK_W-1:0]    shrink_mask_reg, shrink_mask_next;
    logic                 keep_shrunk_reg, keep_shrunk_next;
    logic [DIM_CNT_W-1:0] dim_cnt_reg, dim_cnt_next;
    logic [DIM_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 empty_seen_reg, empty_seen_next;
    logic                 m_valid_reg, m_valid_next;
    ssb_out_t             m_item_reg, m_item_next;

    logic [MASK_EXT_W-1:0] begin_ext, end_ext, shrink_ext;
    logic [DIM_CNT_W:0]    dim_inc;
    logic                  res_valid, res_take, kept;
    ssb_dim_ctl_t          dim_ctl;
    ssb_core_res_t         res;

    assign begin_ext  = {{(MASK_EXT_W-MASK_W){1'b0}}, begin_mask_reg};
    assign end_ext    = {{(MASK_EXT_W-MASK_W){1'b0}}, end_mask_reg};
    assign shrink_ext = {{(MASK_EXT_W-MASK_W){1'b0}}, shrink_mask_reg};

    assign dim_ctl.begin_ign = begin_ext[dim_cnt_reg];
    assign dim_ctl.end_ign   = end_ext[dim_cnt_reg];
    assign dim_ctl.shrink    = shrink_ext[dim_cnt_reg];

    ssb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .dim_ctl   (dim_ctl),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!m_valid_reg || m_ready);
    assign kept     = !empty_seen_reg && (keep_shrunk_reg || !res.shrink);
    assign dim_inc  = {1'b0, dim_cnt_reg} + (DIM_CNT_W+1)'(1);

    always_comb begin
        begin_mask_next  = begin_mask_reg;
        end_mask_next    = end_mask_reg;
        shrink_mask_next = shrink_mask_reg;
        keep_shrunk_next = keep_shrunk_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BEGIN_MASK:  begin_mask_next  = cfg_wdata;
                CFG_END_MASK:    end_mask_next    = cfg_wdata;
                CFG_SHRINK_MASK: shrink_mask_next = cfg_wdata;
                CFG_KEEP_SHRUNK: keep_shrunk_next = cfg_wdata[0];
                default:         keep_shrunk_next = keep_shrunk_reg;
            endcase
        end
    end

    always_comb begin
        dim_cnt_next    = dim_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        empty_seen_next = empty_seen_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        if (res_take) begin
            m_valid_next            = 1'b1;
            m_item_next.start_abs   = res.start_abs;
            m_item_next.end_abs     = res.end_abs;
            m_item_next.stride_out  = res.stride_out;
            m_item_next.out_extent  = '0;
            m_item_next.dim_kept    = kept;
            m_item_next.out_position = kept ? out_cnt_reg : '0;
            m_item_next.last_out    = res.last;
            if (kept) begin
                if (res.range_empty) begin
                    empty_seen_next = 1'b1;
                end else begin
                    m_item_next.out_extent = res.extent;
                    out_cnt_next           = out_cnt_reg + DIM_CNT_W'(1);
                end
            end
            m_item_next.shape_empty = empty_seen_next;
            if (res.last) begin
                dim_cnt_next    = '0;
                out_cnt_next    = '0;
                empty_seen_next = 1'b0;
            end else begin
                dim_cnt_next = (dim_inc >= (DIM_CNT_W+1)'(MAX_DIMS)) ? '0
                             : dim_inc[DIM_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_mask_reg  <= '0;
            end_mask_reg    <= '0;
            shrink_mask_reg <= '0;
            keep_shrunk_reg <= 1'b0;
            dim_cnt_reg     <= '0;
            out_cnt_reg     <= '0;
            empty_seen_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            begin_mask_reg  <= begin_mask_next;
            end_mask_reg    <= end_mask_next;
            shrink_mask_reg <= shrink_mask_next;
            keep_shrunk_reg <= keep_shrunk_next;
            dim_cnt_reg     <= dim_cnt_next;
            out_cnt_reg     <= out_cnt_next;
            empty_seen_reg  <= empty_seen_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |-> (!m_valid_reg || m_ready))
        else $error("output item overwritten");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_take && res.last) |=> (dim_cnt_reg == '0 && out_cnt_reg == '0
                                    && !empty_seen_reg))
        else $error("counters not cleared after last dimension");

    a_dim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dim_cnt_reg < DIM_CNT_W'(MAX_DIMS)) || (MAX_DIMS >= MASK_EXT_W))
        else $error("dimension counter out of range");

    a_extent_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.out_extent != '0)
            |-> (m_item_reg.dim_kept && !m_item_reg.shape_empty))
        else $error("extent given for dropped or empty dimension");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while core busy");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for strided_slice_bounds_top: directed and random dimension items, a
// bit-exact predictor of the slice bounds and a field-by-field result check.
// Depends on ssb_pkg and strided_slice_bounds_top.
module testbench
    import ssb_pkg::*;
();

    localparam int     DIMS_MAX    = 6;
    localparam longint I32_MIN     = -(64'sd1 <<< 31);
    localparam longint I32_MAX     = (64'sd1 <<< 31) - 64'sd1;
    localparam longint SIZE_MAX    = (64'sd1 <<< 31) - 64'sd1;
    localparam int     HOLD_CYCLES = 600;
    localparam int     PHASE_ITEMS = 112;
    localparam int     PHASES      = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MASK_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    ssb_in_t              s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    ssb_out_t             m_item;

    // predictor copy of registers and per-operation counters
    logic [MASK_W-1:0]    begin_ign_m = '0;
    logic [MASK_W-1:0]    end_ign_m   = '0;
    logic [MASK_W-1:0]    shrink_m    = '0;
    logic                 keep_m      = 1'b0;
    logic [DIM_CNT_W-1:0] dim_idx     = '0;
    logic [DIM_CNT_W-1:0] slot_idx    = '0;
    logic                 cut_seen    = 1'b0;

    ssb_in_t  dims_pending[$];
    ssb_out_t bounds_due[$];

    int   dims_sent      = 0;
    int   bounds_checked = 0;
    int   faults         = 0;
    int   settings_used  = 0;
    int   operations     = 0;
    int   tx_pause       = 0;
    int   rx_pause       = 0;
    logic sender_calm    = 1'b0;
    logic receiver_calm  = 1'b0;

    strided_slice_bounds_top #(
        .MAX_DIMS(DIMS_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    always #10 aclk = ~aclk;

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x;
    endfunction

    function automatic ssb_out_t slice_bounds(input ssb_in_t it);
        longint   size;
        longint   stride;
        longint   first;
        longint   stop;
        longint   span;
        longint   r;
        longint   s;
        longint   ext;
        logic     shrink;
        logic     b_ign;
        logic     e_ign;
        ssb_out_t o;
        size   = longint'(it.axis_len);
        b_ign  = (dim_idx < MASK_W) ? begin_ign_m[dim_idx] : 1'b0;
        e_ign  = (dim_idx < MASK_W) ? end_ign_m[dim_idx] : 1'b0;
        shrink = (dim_idx < MASK_W) ? shrink_m[dim_idx] : 1'b0;
        stride = it.has_stride ? longint'(signed'(it.stride_value)) : 64'sd1;
        first  = 0;
        if (it.has_start) begin
            first = longint'(signed'(it.start_value));
            if (b_ign) first = (stride > 0) ? I32_MIN : I32_MAX;
            if (first < 0) first = first + size;
            first = clamp_to(first, 0, size - 1);
        end
        stop = size;
        if (it.has_end) begin
            stop = longint'(signed'(it.end_value));
            if (shrink) stop = first + 1;
            if (e_ign && !shrink) stop = (stride > 0) ? I32_MAX : I32_MIN;
            if (stop < 0) stop = stop + size;
            stop = (stride > 0) ? clamp_to(stop, 0, size) : clamp_to(stop, -1, size - 1);
        end
        span = stop - first;
        o = '0;
        o.start_abs  = first[SIZE_W-1:0];
        o.end_abs    = stop[VAL_W-1:0];
        o.stride_out = stride[VAL_W-1:0];
        if (!cut_seen && (keep_m || !shrink)) begin
            o.dim_kept     = 1'b1;
            o.out_position = slot_idx;
            if (span == 0 || (span < 0 && stride >= 0) || (span > 0 && stride <= 0)) begin
                cut_seen = 1'b1;
            end else begin
                r   = (span < 0) ? -span : span;
                s   = (stride < 0) ? -stride : stride;
                ext = r / s + (((r % s) != 0) ? 1 : 0);
                o.out_extent = ext[SIZE_W-1:0];
                slot_idx = slot_idx + 1'b1;
            end
        end
        o.shape_empty = cut_seen;
        o.last_out    = it.last_dim;
        if (it.last_dim) begin
            dim_idx  = '0;
            slot_idx = '0;
            cut_seen = 1'b0;
        end else begin
            dim_idx = (dim_idx + 1 >= DIMS_MAX) ? '0 : dim_idx + 1'b1;
        end
        return o;
    endfunction

    function automatic ssb_in_t dim_item(input longint size, input longint st, input longint en,
                                         input longint sd, input logic hs, input logic he,
                                         input logic ht, input logic last);
        ssb_in_t it;
        it.axis_len     = size[SIZE_W-1:0];
        it.start_value  = st[VAL_W-1:0];
        it.end_value    = en[VAL_W-1:0];
        it.stride_value = sd[VAL_W-1:0];
        it.has_start    = hs;
        it.has_end      = he;
        it.has_stride   = ht;
        it.last_dim     = last;
        return it;
    endfunction

    function automatic longint pick_size();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return SIZE_MAX;
            2, 3:    return longint'($urandom() & 32'h7FFF_FFFF);
            default: return longint'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic longint pick_index(input longint size);
        case ($urandom_range(0, 9))
            0:       return longint'(signed'($urandom()));
            1:       return I32_MIN;
            2:       return I32_MAX;
            default: begin
                if (size <= 64)
                    return longint'($urandom_range(0, 2 * size + 4)) - size - 2;
                case ($urandom_range(0, 2))
                    0:       return longint'($urandom_range(0, 255));
                    1:       return size - longint'($urandom_range(0, 255));
                    default: return -longint'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    function automatic longint pick_stride();
        longint mag;
        mag = longint'($urandom_range(1, 4));
        case ($urandom_range(0, 11))
            0:       return longint'(signed'($urandom()));
            1:       return I32_MIN;
            2:       return I32_MAX;
            3:       return 0;
            default: return $urandom_range(0, 1) ? -mag : mag;
        endcase
    endfunction

    function automatic int pause_len(input logic calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic flag_fault(input string what);
        faults++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            flag_fault($sformatf("result %0d %s: got %0h, want %0h", bounds_checked, name, got, want));
    endtask

    task automatic compare_bound(input ssb_out_t got);
        ssb_out_t want;
        if (bounds_due.size() == 0) begin
            flag_fault($sformatf("result %0d arrived with nothing outstanding", bounds_checked));
        end else begin
            want = bounds_due.pop_front();
            check_field("start_abs", 64'(got.start_abs), 64'(want.start_abs));
            check_field("end_abs", 64'(got.end_abs), 64'(want.end_abs));
            check_field("stride_out", 64'(got.stride_out), 64'(want.stride_out));
            check_field("out_extent", 64'(got.out_extent), 64'(want.out_extent));
            check_field("dim_kept", 64'(got.dim_kept), 64'(want.dim_kept));
            check_field("out_position", 64'(got.out_position), 64'(want.out_position));
            check_field("shape_empty", 64'(got.shape_empty), 64'(want.shape_empty));
            check_field("last_out", 64'(got.last_out), 64'(want.last_out));
        end
    endtask

    // driver: predict on acceptance, then offer the next pending item after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bounds_due.push_back(slice_bounds(s_item));
                dims_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_pause > 0) begin
                    tx_pause--;
                    s_valid <= 1'b0;
                end else if (dims_pending.size() != 0) begin
                    s_item   <= dims_pending.pop_front();
                    s_valid  <= 1'b1;
                    tx_pause = pause_len(sender_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result, then stall at random unless calm; hold off for long now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                compare_bound(m_item);
                bounds_checked++;
                rx_pause = (bounds_checked % 300 == 150) ? HOLD_CYCLES : pause_len(receiver_calm);
            end
            if (rx_pause > 0) begin
                rx_pause--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input ssb_cfg_idx_t idx, input logic [MASK_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BEGIN_MASK:  begin_ign_m = val;
            CFG_END_MASK:    end_ign_m   = val;
            CFG_SHRINK_MASK: shrink_m    = val;
            CFG_KEEP_SHRUNK: keep_m      = val[0];
            default: ;
        endcase
    endtask

    task automatic set_masks(input logic [MASK_W-1:0] b, input logic [MASK_W-1:0] e,
                             input logic [MASK_W-1:0] sh, input logic k);
        write_reg(CFG_BEGIN_MASK, b);
        write_reg(CFG_END_MASK, e);
        write_reg(CFG_SHRINK_MASK, sh);
        write_reg(CFG_KEEP_SHRUNK, {{(MASK_W-1){1'b0}}, k});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic settle();
        do begin
            @(posedge aclk);
            #1;
        end while (dims_pending.size() != 0 || s_valid || bounds_due.size() != 0);
    endtask

    task automatic add_operation(output int n);
        int     dims;
        logic   broken;
        longint size;
        dims   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
        broken = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < dims; i++) begin
            size = pick_size();
            dims_pending.push_back(dim_item(size, pick_index(size), pick_index(size),
                pick_stride(), $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                $urandom_range(0, 4) != 0, (i == dims - 1) && !broken));
        end
        operations++;
        n = dims;
    endtask

    initial begin
        int              queued;
        int              n;
        logic [MASK_W-1:0] b;
        logic [MASK_W-1:0] e;
        logic [MASK_W-1:0] sh;
        logic            k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // bounds of the fields, wrap, empty range, cut and overlong operation
        dims_pending.push_back(dim_item(1, 0, 0, 0, 0, 0, 0, 1));
        dims_pending.push_back(dim_item(SIZE_MAX, I32_MIN, I32_MAX, 1, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(SIZE_MAX, I32_MAX, I32_MIN, -1, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(10, -3, -1, 1, 1, 1, 1, 0));
        dims_pending.push_back(dim_item(10, 8, 2, -3, 1, 1, 1, 0));
        dims_pending.push_back(dim_item(7, 0, 7, I32_MAX, 1, 1, 1, 0));
        dims_pending.push_back(dim_item(7, 6, -8, I32_MIN, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(5, 1, 4, 0, 1, 1, 1, 0));
        dims_pending.push_back(dim_item(5, 0, 5, 1, 1, 1, 1, 0));
        dims_pending.push_back(dim_item(5, 4, 0, -2, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(0, 3, 3, 1, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(0, -2, -5, -1, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(4, 2, 2, 1, 1, 1, 1, 1));
        dims_pending.push_back(dim_item(4, 1, 3, -1, 1, 1, 1, 1));
        for (int i = 0; i < 8; i++)
            dims_pending.push_back(dim_item(3 + i, i, -1, 1, 1, 1, 1, i == 7));
        settle();

        // masks by dimension: begin on 0 and 2, end on 1 to 3, shrink on 1, 4 and 5
        set_masks(6'b000101, 6'b001110, 6'b110010, 1'b0);
        for (int i = 0; i < 6; i++)
            dims_pending.push_back(dim_item(9, i - 3, 2 * i - 4, (i % 2) ? -2 : 1, 1, 1, 1, i == 5));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin b = 6'h3F; e = 6'h3F; sh = 6'h3F; k = 1'b1; end
                1: begin b = 6'h3F; e = 6'h3F; sh = 6'h3F; k = 1'b0; end
                2: begin b = 6'h00; e = 6'h00; sh = 6'h00; k = 1'b0; end
                3: begin b = 6'h00; e = 6'h3F; sh = 6'h00; k = 1'b1; end
                default: begin
                    b  = $urandom_range(0, 63);
                    e  = $urandom_range(0, 63);
                    sh = $urandom_range(0, 63);
                    k  = $urandom_range(0, 1);
                end
            endcase
            set_masks(b, e, sh, k);
            sender_calm   = (p % 3 == 1);
            receiver_calm = (p % 3 == 2);
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                add_operation(n);
                queued += n;
            end
            settle();
        end

        repeat (60) @(posedge aclk);
        if (bounds_due.size() != 0)
            flag_fault($sformatf("%0d results never arrived", bounds_due.size()));
        $display("covered %0d dimension items in %0d random operations over %0d mask settings",
                 dims_sent, operations, settings_used);
        $display("compared %0d results, %0d faults", bounds_checked, faults);
        if (faults == 0)
            $display("strided_slice_bounds_top: match");
        else
            $display("strided_slice_bounds_top: mismatch");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timed out with %0d results outstanding", bounds_due.size());
        $display("strided_slice_bounds_top: mismatch");
        $finish;
    end

endmodule
